### rtl/apor_pkg.sv
// Package for the box push-out resolver: widths, codes, stage types and the clamp function.
package apor_pkg;

	// Coordinate range used for saturation; held to 16..32 since fields are 32 bits wide.
	localparam int COORD_WIDTH = 32;

	localparam int POS_W  = 32;
	localparam int HALF_W = 30;
	localparam int SUM_W  = HALF_W + 1;
	localparam int EXT_W  = POS_W + 2;
	localparam int NUM_AXES = 3;
	localparam int CFG_IDX_W = 2;

	localparam int EFF_W = (COORD_WIDTH > 32) ? 32 : ((COORD_WIDTH < 16) ? 16 : COORD_WIDTH);
	localparam logic signed [EXT_W-1:0] CLAMP_HI = (EXT_W'(1) <<< (EFF_W - 1)) - EXT_W'(1);
	localparam logic signed [EXT_W-1:0] CLAMP_LO = -(EXT_W'(1) <<< (EFF_W - 1));

	localparam logic [HALF_W-1:0] HALF_RESET = HALF_W'(65536);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_HALF_X = 2'd0,
		REG_HALF_Y = 2'd1,
		REG_HALF_Z = 2'd2
	} cfg_reg_t;

	typedef enum logic [1:0] {
		AXIS_NONE = 2'd0,
		AXIS_X    = 2'd1,
		AXIS_Y    = 2'd2,
		AXIS_Z    = 2'd3
	} axis_code_t;

	typedef enum logic {
		REQ_LOAD    = 1'b0,
		REQ_RESOLVE = 1'b1
	} req_code_t;

	typedef struct packed {
		logic signed [POS_W-1:0] val;
		logic                    clip;
	} clamp_t;

	// Per-axis work prepared from the input and the mover half-extent registers
	typedef struct packed {
		logic signed [POS_W-1:0] pos;
		logic [SUM_W-1:0]        w;
		logic signed [POS_W-1:0] up;
		logic                    up_clip;
		logic signed [POS_W-1:0] dn;
		logic                    dn_clip;
	} axis_prep_t;

	typedef struct packed {
		logic                       load;
		logic                       present;
		axis_prep_t [NUM_AXES-1:0]  ax;
	} prep_t;

	function automatic clamp_t clamp_coord(input logic signed [EXT_W-1:0] v);
		clamp_t r;
		if (v > CLAMP_HI) begin
			r.val  = CLAMP_HI[POS_W-1:0];
			r.clip = 1'b1;
		end else if (v < CLAMP_LO) begin
			r.val  = CLAMP_LO[POS_W-1:0];
			r.clip = 1'b1;
		end else begin
			r.val  = v[POS_W-1:0];
			r.clip = 1'b0;
		end
		return r;
	endfunction

endpackage

### rtl/apor_ifs.sv
// Channel interfaces: request stream in, result stream out.
interface apor_in_if import apor_pkg::*;;
	logic                     valid;
	logic                     ready;
	logic                     req_type;
	logic signed [POS_W-1:0]  pos_x;
	logic signed [POS_W-1:0]  pos_y;
	logic signed [POS_W-1:0]  pos_z;
	logic [HALF_W-1:0]        box_half_x;
	logic [HALF_W-1:0]        box_half_y;
	logic [HALF_W-1:0]        box_half_z;
	logic                     box_present;

	modport source(output valid, req_type, pos_x, pos_y, pos_z, box_half_x, box_half_y,
		box_half_z, box_present, input ready);
	modport sink(input valid, req_type, pos_x, pos_y, pos_z, box_half_x, box_half_y,
		box_half_z, box_present, output ready);
endinterface

interface apor_out_if import apor_pkg::*;;
	logic                     valid;
	logic                     ready;
	logic signed [POS_W-1:0]  mover_x;
	logic signed [POS_W-1:0]  mover_y;
	logic signed [POS_W-1:0]  mover_z;
	logic [1:0]               push_axis;
	logic                     clipped;

	modport source(output valid, mover_x, mover_y, mover_z, push_axis, clipped, input ready);
	modport sink(input valid, mover_x, mover_y, mover_z, push_axis, clipped, output ready);
endinterface

### rtl/apor_prep.sv
// Input stage: config registers, input register with halves sums and clamped push targets.
module apor_prep import apor_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [HALF_W-1:0]    cfg_wdata,
	apor_in_if.sink              in_ch,
	output prep_t                s1_data,
	output logic                 s1_valid,
	input  logic                 s1_ready
);

	logic [HALF_W-1:0]       mover_half_q [NUM_AXES];
	logic                    s1_valid_q;
	prep_t                   data_s1;
	prep_t                   nxt;
	logic signed [POS_W-1:0] pos_in  [NUM_AXES];
	logic [HALF_W-1:0]       box_in  [NUM_AXES];
	logic [SUM_W-1:0]        w_sum   [NUM_AXES];
	logic signed [EXT_W-1:0] up_sum  [NUM_AXES];
	logic signed [EXT_W-1:0] dn_sum  [NUM_AXES];
	clamp_t                  up_c    [NUM_AXES];
	clamp_t                  dn_c    [NUM_AXES];
	logic                    in_take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int a = 0; a < NUM_AXES; a++) begin
				mover_half_q[a] <= HALF_RESET;
			end
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_idx))
				REG_HALF_X: mover_half_q[0] <= cfg_wdata;
				REG_HALF_Y: mover_half_q[1] <= cfg_wdata;
				REG_HALF_Z: mover_half_q[2] <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign in_ch.ready = !s1_valid_q || s1_ready;
	assign in_take     = in_ch.valid && in_ch.ready;

	always_comb begin
		pos_in[0] = in_ch.pos_x;
		pos_in[1] = in_ch.pos_y;
		pos_in[2] = in_ch.pos_z;
		box_in[0] = in_ch.box_half_x;
		box_in[1] = in_ch.box_half_y;
		box_in[2] = in_ch.box_half_z;
		nxt.load    = (req_code_t'(in_ch.req_type) == REQ_LOAD);
		nxt.present = in_ch.box_present;
		for (int a = 0; a < NUM_AXES; a++) begin
			w_sum[a]  = {1'b0, mover_half_q[a]} + {1'b0, box_in[a]};
			up_sum[a] = {{2{pos_in[a][POS_W-1]}}, pos_in[a]} + {3'b000, w_sum[a]};
			dn_sum[a] = {{2{pos_in[a][POS_W-1]}}, pos_in[a]} - {3'b000, w_sum[a]};
			up_c[a]   = clamp_coord(up_sum[a]);
			dn_c[a]   = clamp_coord(dn_sum[a]);
			nxt.ax[a].pos     = pos_in[a];
			nxt.ax[a].w       = w_sum[a];
			nxt.ax[a].up      = up_c[a].val;
			nxt.ax[a].up_clip = up_c[a].clip;
			nxt.ax[a].dn      = dn_c[a].val;
			nxt.ax[a].dn_clip = dn_c[a].clip;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_ch.ready) begin
			s1_valid_q <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			data_s1 <= nxt;
		end
	end

	assign s1_data  = data_s1;
	assign s1_valid = s1_valid_q;

	// a held item must not drop out while the resolve stage stalls
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q && !s1_ready |=> s1_valid_q)
		else $error("prepared transaction lost while stalled");

endmodule

### rtl/apor_resolve.sv
// Resolve stage: overlap test against the stored centre, axis pick, centre update, result register.
module apor_resolve import apor_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  prep_t     s1_data,
	input  logic      s1_valid,
	output logic      s1_ready,
	apor_out_if.source out_ch
);

	logic signed [POS_W-1:0]   centre_q [NUM_AXES];
	logic signed [POS_W-1:0]   out_pos_q [NUM_AXES];
	axis_code_t                out_axis_q;
	logic                      out_clip_q;
	logic                      out_valid_q;

	logic signed [POS_W:0]     diff  [NUM_AXES];
	logic [POS_W:0]            mag   [NUM_AXES];
	logic signed [EXT_W-1:0]   ovl   [NUM_AXES];
	logic                      ovl_pos [NUM_AXES];
	logic                      away_up [NUM_AXES];
	logic signed [POS_W-1:0]   centre_nxt [NUM_AXES];
	axis_code_t                axis_nxt;
	logic                      clip_nxt;
	logic                      advance;
	int unsigned               sel;

	assign s1_ready = !out_valid_q || out_ch.ready;
	assign advance  = s1_valid && s1_ready;

	always_comb begin
		for (int a = 0; a < NUM_AXES; a++) begin
			diff[a]    = {centre_q[a][POS_W-1], centre_q[a]}
				- {s1_data.ax[a].pos[POS_W-1], s1_data.ax[a].pos};
			// magnitude of the most negative difference wraps to 2^32, correct as unsigned
			mag[a]     = diff[a][POS_W] ? -diff[a] : diff[a];
			ovl[a]     = {3'b000, s1_data.ax[a].w} - {1'b0, mag[a]};
			ovl_pos[a] = !ovl[a][EXT_W-1] && (ovl[a] != '0);
			away_up[a] = !diff[a][POS_W] && (diff[a] != '0);
			centre_nxt[a] = centre_q[a];
		end
		axis_nxt = AXIS_NONE;
		clip_nxt = 1'b0;
		sel      = 0;
		if (s1_data.load) begin
			for (int a = 0; a < NUM_AXES; a++) begin
				centre_nxt[a] = s1_data.ax[a].pos;
			end
		end else if (s1_data.present && ovl_pos[0] && ovl_pos[1] && ovl_pos[2]) begin
			// ties never go to x; an x/y tie goes to y, and any tie with z goes to z
			if (ovl[0] < ovl[1] && ovl[0] < ovl[2]) begin
				axis_nxt = AXIS_X;
				sel      = 0;
			end else if (ovl[1] < ovl[2]) begin
				axis_nxt = AXIS_Y;
				sel      = 1;
			end else begin
				axis_nxt = AXIS_Z;
				sel      = 2;
			end
			for (int a = 0; a < NUM_AXES; a++) begin
				if (sel == a) begin
					centre_nxt[a] = away_up[a] ? s1_data.ax[a].up : s1_data.ax[a].dn;
					clip_nxt      = away_up[a] ? s1_data.ax[a].up_clip : s1_data.ax[a].dn_clip;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int a = 0; a < NUM_AXES; a++) begin
				centre_q[a] <= '0;
			end
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				for (int a = 0; a < NUM_AXES; a++) begin
					centre_q[a] <= centre_nxt[a];
				end
			end
			if (s1_ready) begin
				out_valid_q <= s1_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			for (int a = 0; a < NUM_AXES; a++) begin
				out_pos_q[a] <= centre_nxt[a];
			end
			out_axis_q <= axis_nxt;
			out_clip_q <= clip_nxt;
		end
	end

	assign out_ch.valid     = out_valid_q;
	assign out_ch.mover_x   = out_pos_q[0];
	assign out_ch.mover_y   = out_pos_q[1];
	assign out_ch.mover_z   = out_pos_q[2];
	assign out_ch.push_axis = out_axis_q;
	assign out_ch.clipped   = out_clip_q;

	a_result_is_centre: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_pos_q[0] == centre_q[0]) && (out_pos_q[1] == centre_q[1])
			&& (out_pos_q[2] == centre_q[2]))
		else $error("pending result disagrees with stored centre");

	a_clip_needs_push: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_clip_q |-> out_axis_q != AXIS_NONE)
		else $error("clip flagged without a push");

	a_load_no_push: assert property (@(posedge clk) disable iff (!arst_n)
		advance && s1_data.load |=> out_axis_q == AXIS_NONE && !out_clip_q)
		else $error("load transaction reported a push");

	a_centre_still: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(centre_q[0]) && $stable(centre_q[1]) && $stable(centre_q[2]))
		else $error("centre moved without a transaction");

endmodule

### rtl/aabb_push_out_resolver_unit.sv
// The result passes through the input register and then the result register; a stall
// on the result channel holds it. Throughput: one transaction per cycle while unstalled;
// the stored centre is read, compared and rewritten in the single resolve stage, so each
// item sees the centre left by the one before it.
// Reset (arst_n low, asynchronous): centre cleared to zero, mover half-extents to 1.0,
// both stages emptied; no clearing pass is needed.
module aabb_push_out_resolver_unit import apor_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [HALF_W-1:0]    cfg_wdata,
	apor_in_if.sink              in_ch,
	apor_out_if.source           out_ch
);

	prep_t s1_data;
	logic  s1_valid;
	logic  s1_ready;

	apor_prep u_prep (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.in_ch     (in_ch),
		.s1_data   (s1_data),
		.s1_valid  (s1_valid),
		.s1_ready  (s1_ready)
	);

	apor_resolve u_resolve (
		.clk      (clk),
		.arst_n   (arst_n),
		.s1_data  (s1_data),
		.s1_valid (s1_valid),
		.s1_ready (s1_ready),
		.out_ch   (out_ch)
	);

endmodule

### bench/tb_aabb_push_out_resolver_unit.sv
// Self-checking bench for the box push-out resolver: stream driver, result monitor, predictor.
module tb_aabb_push_out_resolver_unit;
	import apor_pkg::*;

	localparam int CLK_HALF   = 6;
	localparam int RUN_LIMIT  = 400000;
	localparam int RAND_ITEMS = 950;
	localparam int NUM_PHASES = 5;
	localparam int UNIT       = 65536;
	localparam logic [HALF_W-1:0] HALF_MAX = '1;
	localparam int SAT_W = (COORD_WIDTH > 32) ? 32 : ((COORD_WIDTH < 16) ? 16 : COORD_WIDTH);
	localparam longint SAT_HI = (longint'(1) <<< (SAT_W - 1)) - 1;
	localparam longint SAT_LO = -(longint'(1) <<< (SAT_W - 1));

	typedef struct {
		req_code_t               kind;
		logic signed [POS_W-1:0] px, py, pz;
		logic [HALF_W-1:0]       hx, hy, hz;
		logic                    present;
	} box_req_t;

	typedef struct {
		logic signed [POS_W-1:0] x, y, z;
		axis_code_t              axis;
		logic                    clip;
	} mover_rec_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [HALF_W-1:0]    cfg_wdata;

	apor_in_if  box_ch();
	apor_out_if mover_ch();

	aabb_push_out_resolver_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_wdata(cfg_wdata),
		.in_ch    (box_ch),
		.out_ch   (mover_ch)
	);

	box_req_t   pending_q[$];
	mover_rec_t mover_q[$];

	// predictor copy of the block's state and half-extent registers
	logic signed [POS_W-1:0] ctr_x, ctr_y, ctr_z;
	logic [HALF_W-1:0]       mh_x, mh_y, mh_z;

	logic signed [POS_W-1:0] anchor[3];
	int n_queued, n_accepted, n_errors;
	bit box_taken;
	int send_gap, stall_left;
	bit send_calm, recv_calm;

	initial forever #CLK_HALF clk = ~clk;

	function automatic mover_rec_t predict_mover(input box_req_t r);
		longint     p[3], d[3], w[3], t[3];
		longint     nv;
		int         ax;
		mover_rec_t m;
		m.axis = AXIS_NONE;
		m.clip = 1'b0;
		if (r.kind == REQ_LOAD) begin
			ctr_x = r.px;
			ctr_y = r.py;
			ctr_z = r.pz;
		end else if (r.present) begin
			p[0] = r.px;
			p[1] = r.py;
			p[2] = r.pz;
			d[0] = ctr_x - p[0];
			d[1] = ctr_y - p[1];
			d[2] = ctr_z - p[2];
			w[0] = mh_x + r.hx;
			w[1] = mh_y + r.hy;
			w[2] = mh_z + r.hz;
			for (int i = 0; i < 3; i++)
				t[i] = w[i] - ((d[i] < 0) ? -d[i] : d[i]);
			if (t[0] > 0 && t[1] > 0 && t[2] > 0) begin
				// x wins only when strictly least, y beats z only when strictly below
				if (t[0] < t[1] && t[0] < t[2])
					ax = 0;
				else if (t[1] < t[2])
					ax = 1;
				else
					ax = 2;
				nv = (d[ax] > 0) ? p[ax] + w[ax] : p[ax] - w[ax];
				if (nv > SAT_HI) begin
					nv = SAT_HI;
					m.clip = 1'b1;
				end else if (nv < SAT_LO) begin
					nv = SAT_LO;
					m.clip = 1'b1;
				end
				case (ax)
					0: begin
						ctr_x = nv[POS_W-1:0];
						m.axis = AXIS_X;
					end
					1: begin
						ctr_y = nv[POS_W-1:0];
						m.axis = AXIS_Y;
					end
					default: begin
						ctr_z = nv[POS_W-1:0];
						m.axis = AXIS_Z;
					end
				endcase
			end
		end
		m.x = ctr_x;
		m.y = ctr_y;
		m.z = ctr_z;
		return m;
	endfunction

	function automatic void check_field(input string name, input logic signed [63:0] want,
			input logic signed [63:0] got);
		if (want !== got) begin
			n_errors++;
			$display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
		end
	endfunction

	function automatic int idle_len(input bit calm);
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 50)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Mostly boxes scattered around the anchor of the last non-noise load so overlaps are common;
	// some loads (a few at the coordinate extremes) and some pure noise.
	function automatic box_req_t random_req();
		box_req_t r;
		int       pick;
		longint   pos[3];
		pick = $urandom_range(0, 99);
		r.kind = REQ_RESOLVE;
		r.present = 1'b1;
		r.px = $urandom;
		r.py = $urandom;
		r.pz = $urandom;
		r.hx = HALF_W'($urandom);
		r.hy = HALF_W'($urandom);
		r.hz = HALF_W'($urandom);
		if (pick < 8) begin
			r.kind = $urandom_range(0, 1) ? REQ_RESOLVE : REQ_LOAD;
			r.present = 1'($urandom_range(0, 1));
		end else if (pick < 22) begin
			r.kind = REQ_LOAD;
			r.present = 1'($urandom_range(0, 1));
			for (int i = 0; i < 3; i++) begin
				case ($urandom_range(0, 9))
					0: anchor[i] = 32'h7FFF_FFFF - $urandom_range(0, 4 * UNIT);
					1: anchor[i] = 32'h8000_0000 + $urandom_range(0, 4 * UNIT);
					default: anchor[i] = int'($urandom_range(0, 1 << 22)) - (1 << 21);
				endcase
			end
			r.px = anchor[0];
			r.py = anchor[1];
			r.pz = anchor[2];
		end else begin
			r.present = ($urandom_range(0, 19) != 0);
			if ($urandom_range(0, 19) != 0) begin
				r.hx = HALF_W'($urandom_range(0, 4 * UNIT));
				r.hy = HALF_W'($urandom_range(0, 4 * UNIT));
				r.hz = HALF_W'($urandom_range(0, 4 * UNIT));
			end
			for (int i = 0; i < 3; i++)
				pos[i] = longint'(anchor[i]) + int'($urandom_range(0, 6 * UNIT)) - 3 * UNIT;
			r.px = pos[0][POS_W-1:0];
			r.py = pos[1][POS_W-1:0];
			r.pz = pos[2][POS_W-1:0];
		end
		return r;
	endfunction

	task automatic put(input req_code_t k, input int x, input int y, input int z,
			input int hx, input int hy, input int hz, input bit pres);
		box_req_t r;
		r.kind = k;
		r.px = x;
		r.py = y;
		r.pz = z;
		r.hx = HALF_W'(hx);
		r.hy = HALF_W'(hy);
		r.hz = HALF_W'(hz);
		r.present = pres;
		pending_q.push_back(r);
		n_queued++;
	endtask

	task automatic write_half(input cfg_reg_t idx, input logic [HALF_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic settle();
		while (n_accepted != n_queued || mover_q.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	// request driver
	always @(negedge clk) begin : feeder
		box_req_t nxt;
		if (!arst_n) begin
			box_ch.valid <= 1'b0;
		end else if (!box_ch.valid || box_taken) begin
			if (send_gap > 0) begin
				box_ch.valid <= 1'b0;
				send_gap--;
			end else if (pending_q.size() != 0) begin
				nxt = pending_q.pop_front();
				box_ch.req_type <= nxt.kind;
				box_ch.pos_x <= nxt.px;
				box_ch.pos_y <= nxt.py;
				box_ch.pos_z <= nxt.pz;
				box_ch.box_half_x <= nxt.hx;
				box_ch.box_half_y <= nxt.hy;
				box_ch.box_half_z <= nxt.hz;
				box_ch.box_present <= nxt.present;
				box_ch.valid <= 1'b1;
				send_gap = idle_len(send_calm);
				if ($urandom_range(0, 49) == 0)
					send_calm = !send_calm;
			end else begin
				box_ch.valid <= 1'b0;
			end
		end
	end

	// result back-pressure
	always @(negedge clk) begin
		if (stall_left > 0) begin
			mover_ch.ready <= 1'b0;
			stall_left--;
		end else begin
			mover_ch.ready <= 1'b1;
			stall_left = idle_len(recv_calm);
			if ($urandom_range(0, 63) == 0)
				recv_calm = !recv_calm;
		end
	end

	// predictor and result check on each rising edge
	always @(posedge clk) begin : scoreboard
		box_req_t   seen;
		mover_rec_t want;
		if (!arst_n) begin
			box_taken <= 1'b0;
			ctr_x = '0;
			ctr_y = '0;
			ctr_z = '0;
			mh_x = HALF_RESET;
			mh_y = HALF_RESET;
			mh_z = HALF_RESET;
		end else begin
			box_taken <= box_ch.valid && box_ch.ready;
			if (cfg_we) begin
				case (cfg_idx)
					REG_HALF_X: mh_x = cfg_wdata;
					REG_HALF_Y: mh_y = cfg_wdata;
					REG_HALF_Z: mh_z = cfg_wdata;
					default: ;
				endcase
			end
			if (box_ch.valid && box_ch.ready) begin
				seen.kind = req_code_t'(box_ch.req_type);
				seen.px = box_ch.pos_x;
				seen.py = box_ch.pos_y;
				seen.pz = box_ch.pos_z;
				seen.hx = box_ch.box_half_x;
				seen.hy = box_ch.box_half_y;
				seen.hz = box_ch.box_half_z;
				seen.present = box_ch.box_present;
				mover_q.push_back(predict_mover(seen));
				n_accepted++;
			end
			if (mover_ch.valid && mover_ch.ready) begin
				if (mover_q.size() == 0) begin
					n_errors++;
					$display(
						"%0t: unexpected transaction: expected none, actual %0d %0d %0d %s",
						$time, mover_ch.mover_x, mover_ch.mover_y, mover_ch.mover_z,
						$sformatf("axis %0d clip %0d", mover_ch.push_axis,
						mover_ch.clipped));
				end else begin
					want = mover_q.pop_front();
					check_field("mover_x", want.x, mover_ch.mover_x);
					check_field("mover_y", want.y, mover_ch.mover_y);
					check_field("mover_z", want.z, mover_ch.mover_z);
					check_field("push_axis", want.axis, mover_ch.push_axis);
					check_field("clipped", want.clip, mover_ch.clipped);
				end
			end
		end
	end

	initial begin : watchdog
		int cycles;
		cycles = 0;
		while (cycles < RUN_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("[aabb_push_out_resolver_unit] ERROR");
		$finish;
	end

	initial begin : stimulus
		logic [HALF_W-1:0] hv[3];
		cfg_we = 1'b0;
		cfg_idx = REG_HALF_X;
		cfg_wdata = '0;
		box_ch.valid = 1'b0;
		box_ch.req_type = REQ_LOAD;
		box_ch.pos_x = '0;
		box_ch.pos_y = '0;
		box_ch.pos_z = '0;
		box_ch.box_half_x = '0;
		box_ch.box_half_y = '0;
		box_ch.box_half_z = '0;
		box_ch.box_present = 1'b0;
		mover_ch.ready = 1'b0;
		n_queued = 0;
		n_accepted = 0;
		n_errors = 0;
		send_gap = 0;
		stall_left = 0;
		send_calm = 1'b0;
		recv_calm = 1'b0;
		for (int i = 0; i < 3; i++)
			anchor[i] = '0;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;

		write_half(REG_HALF_X, HALF_W'(UNIT));
		write_half(REG_HALF_Y, HALF_W'(UNIT));
		write_half(REG_HALF_Z, HALF_W'(UNIT));

		// box fields are don't-care on a load
		put(REQ_LOAD, 0, 0, 0, HALF_MAX, HALF_MAX, HALF_MAX, 1'b1);
		put(REQ_RESOLVE, UNIT / 2, 0, 0, UNIT, UNIT, UNIT, 1'b0);
		put(REQ_RESOLVE, 5 * UNIT, 0, 0, UNIT, UNIT, UNIT, 1'b1);
		// touching faces: zero overlap, no push
		put(REQ_RESOLVE, 2 * UNIT, 0, 0, UNIT, UNIT, UNIT, 1'b1);
		put(REQ_RESOLVE, 3 * UNIT / 2, 0, 0, UNIT, UNIT, UNIT, 1'b1);
		put(REQ_LOAD, 0, 0, 0, 0, 0, 0, 1'b0);
		put(REQ_RESOLVE, 0, -3 * UNIT / 2, 0, UNIT, UNIT, UNIT, 1'b1);
		put(REQ_LOAD, 0, 0, 0, 0, 0, 0, 1'b1);
		put(REQ_RESOLVE, 0, 0, 3 * UNIT / 2, UNIT, UNIT, UNIT, 1'b1);
		// x/y tie resolves to y, y/z tie to z
		put(REQ_LOAD, 0, 0, 0, 0, 0, 0, 1'b1);
		put(REQ_RESOLVE, 3 * UNIT / 2, 3 * UNIT / 2, 0, UNIT, UNIT, UNIT, 1'b1);
		put(REQ_LOAD, 0, 0, 0, 0, 0, 0, 1'b1);
		put(REQ_RESOLVE, 0, 3 * UNIT / 2, 3 * UNIT / 2, UNIT, UNIT, UNIT, 1'b1);
		// coincident centres: all axes tie, push goes negative
		put(REQ_LOAD, 0, 0, 0, 0, 0, 0, 1'b1);
		put(REQ_RESOLVE, 0, 0, 0, UNIT, UNIT, UNIT, 1'b1);
		put(REQ_LOAD, 0, 0, 0, 0, 0, 0, 1'b1);
		put(REQ_RESOLVE, 0, 0, 0, 0, 5 * UNIT, 5 * UNIT, 1'b1);
		// saturation at both ends of the range
		put(REQ_LOAD, 32'h7FFF_0000, 0, 0, 0, 0, 0, 1'b1);
		put(REQ_RESOLVE, 32'h7FFE_0000, 0, 0, 2 * UNIT, 5 * UNIT, 5 * UNIT, 1'b1);
		put(REQ_LOAD, 32'h8000_0000, 0, 0, 0, 0, 0, 1'b1);
		put(REQ_RESOLVE, 32'h8001_0000, 0, 0, 2 * UNIT, 5 * UNIT, 5 * UNIT, 1'b1);
		put(REQ_LOAD, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, 0, 1'b1);
		put(REQ_RESOLVE, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			HALF_MAX, HALF_MAX, HALF_MAX, 1'b1);
		put(REQ_LOAD, 0, 0, 0, 0, 0, 0, 1'b1);
		put(REQ_RESOLVE, 1, 1, 1, HALF_MAX, HALF_MAX, HALF_MAX, 1'b1);
		settle();

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			case (ph)
				0: begin
					hv[0] = '0;
					hv[1] = '0;
					hv[2] = '0;
				end
				1: begin
					hv[0] = HALF_MAX;
					hv[1] = HALF_MAX;
					hv[2] = HALF_MAX;
				end
				2: begin
					hv[0] = HALF_W'($urandom_range(0, 8 * UNIT));
					hv[1] = HALF_W'($urandom_range(0, 8 * UNIT));
					hv[2] = HALF_W'($urandom_range(0, 8 * UNIT));
				end
				3: begin
					hv[0] = HALF_W'($urandom);
					hv[1] = HALF_W'($urandom);
					hv[2] = HALF_W'($urandom);
				end
				default: begin
					hv[0] = '0;
					hv[1] = HALF_MAX;
					hv[2] = HALF_W'($urandom_range(0, 4 * UNIT));
				end
			endcase
			write_half(REG_HALF_X, hv[0]);
			write_half(REG_HALF_Y, hv[1]);
			write_half(REG_HALF_Z, hv[2]);
			repeat (RAND_ITEMS / NUM_PHASES) begin
				pending_q.push_back(random_req());
				n_queued++;
			end
			settle();
		end

		repeat (8) @(posedge clk);
		if (n_errors == 0)
			$display("[aabb_push_out_resolver_unit] OK");
		else
			$display("[aabb_push_out_resolver_unit] ERROR");
		$finish;
	end

endmodule

### files.f
rtl/apor_pkg.sv
rtl/apor_ifs.sv
rtl/apor_prep.sv
rtl/apor_resolve.sv
rtl/aabb_push_out_resolver_unit.sv
bench/tb_aabb_push_out_resolver_unit.sv
